// ===== sv/assert_macros.svh =====
// Assertion macros shared by the matrix inverse RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== sv/mi3_pkg.sv =====
// Shared types and constants of the 3x3 matrix inverse.
package mi3_pkg;
    localparam int FRAC_BITS = 20;
    localparam int EW        = 32;
    localparam int PW        = 64;
    localparam int AW        = 65;
    localparam int DW        = 97;
    localparam int NW        = AW + 2 * FRAC_BITS + 1;
    localparam int QW        = NW;
    localparam int QDEPTH    = 4;
    localparam int QPW       = 2;

    typedef logic signed [EW-1:0] t_elem;
    typedef logic signed [AW-1:0] t_adj;
    typedef logic signed [DW-1:0] t_det;

    // Item handed from the front end to the divider back end.
    typedef struct packed {
        t_adj [8:0] adj;
        t_det       det;
    } t_job;

    // Queue status toward the front end.
    typedef struct packed {
        logic           full;
        logic [QPW:0]   count;
        logic           empty;
    } t_qstat;
endpackage

// ===== sv/mi3_front.sv =====
// Front end: adjugate and determinant pipeline.
module mi3_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  mi3_pkg::t_elem i_m [9],
    output logic          o_valid,
    output mi3_pkg::t_job o_job
);
    import mi3_pkg::*;

    logic          r_v1, r_v2, r_v3;
    logic signed [PW-1:0] r_p [18];
    t_elem         r_m1 [3];
    t_adj          r_adj2 [9];
    t_elem         r_m2 [3];
    logic signed [EW+32:0] r_pl [3];
    logic signed [EW+32:0] r_ph [3];
    t_adj          r_adj3 [9];

    // Element index of each factor of the cross products, two products per adjugate element.
    function automatic logic [3:0] ia(input int k);
        int t [36];
        t = '{4,8,5,7, 2,7,1,8, 1,5,2,4, 5,6,3,8, 0,8,2,6,
              2,3,0,5, 3,7,4,6, 1,6,0,7, 0,4,1,3};
        return 4'(t[k]);
    endfunction

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 18; k++) begin
            r_p[k] <= PW'(i_m[ia(2*k)]) * PW'(i_m[ia(2*k+1)]);
        end
        for (int k = 0; k < 3; k++) r_m1[k] <= i_m[k];
        for (int k = 0; k < 9; k++) begin
            r_adj2[k] <= AW'(r_p[2*k]) - AW'(r_p[2*k+1]);
        end
        r_m2 <= r_m1;
        // Each determinant term is split at bit 32 of its adjugate element.
        for (int k = 0; k < 3; k++) begin
            r_pl[k] <= r_m2[k] * $signed({1'b0, r_adj2[3*k][31:0]});
            r_ph[k] <= r_m2[k] * $signed(r_adj2[3*k][AW-1:32]);
        end
        r_adj3 <= r_adj2;
        for (int k = 0; k < 9; k++) o_job.adj[k] <= r_adj3[k];
        o_job.det <= (DW'(r_ph[0]) <<< 32) + DW'(r_pl[0])
                   + (DW'(r_ph[1]) <<< 32) + DW'(r_pl[1])
                   + (DW'(r_ph[2]) <<< 32) + DW'(r_pl[2]);
    end

    // Valid pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; o_valid <= 1'b0;
        end else begin
            r_v1 <= i_valid; r_v2 <= r_v1; r_v3 <= r_v2; o_valid <= r_v3;
        end
    end
endmodule

// ===== sv/mi3_queue.sv =====
// Short queue of jobs between front end and back end.
module mi3_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mi3_pkg::t_job   i_job,
    input  logic            i_pop,
    output mi3_pkg::t_job   o_job,
    output mi3_pkg::t_qstat o_stat
);
    import mi3_pkg::*;
    `include "assert_macros.svh"

    t_job              r_mem [QDEPTH];
    logic [QPW-1:0]    r_wp, r_rp;
    logic [QPW:0]      r_cnt;

    // Storage.
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end
    assign o_job = r_mem[r_rp];

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPW+1)'(i_push) - (QPW+1)'(i_pop);
        end
    end

    assign o_stat.full  = (r_cnt == (QPW+1)'(QDEPTH));
    assign o_stat.count = r_cnt;
    assign o_stat.empty = (r_cnt == '0);

    `ASSERT_IMPLY(a_no_overrun, i_clk, i_rst_n, o_stat.full, !i_push || i_pop,
        "queue overrun")
    `ASSERT_IMPLY(a_no_underrun, i_clk, i_rst_n, o_stat.empty, !i_pop,
        "queue underrun")
endmodule

// ===== sv/mi3_back.sv =====
// Back end: nine bit-serial dividers with rounding and saturation.
module mi3_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_avail,
    input  mi3_pkg::t_job   i_job,
    output logic            o_pop,
    output logic            o_valid,
    output mi3_pkg::t_elem  o_r [9],
    output logic            o_singular,
    output logic            o_overflowed
);
    import mi3_pkg::*;
    `include "assert_macros.svh"

    localparam int CW = $clog2(QW + 1);

    logic               r_busy;
    logic [CW-1:0]      r_cnt;
    logic [NW-1:0]      r_num [9];
    logic [QW-1:0]      r_q   [9];
    logic [DW:0]        r_rem [9];
    logic [DW:0]        r_d2;
    logic [8:0]         r_neg;
    logic               r_sing;

    logic [DW-1:0]      dmag;
    logic [AW-1:0]      amag [9];
    logic               dneg;

    assign dneg = i_job.det[DW-1];
    assign dmag = dneg ? DW'(-i_job.det) : DW'(i_job.det);
    assign o_pop  = i_avail && !r_busy;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            amag[k] = i_job.adj[k][AW-1] ? AW'(-i_job.adj[k]) : AW'(i_job.adj[k]);
        end
    end

    // Restoring division, one quotient bit per cycle for every element.
    always_ff @(posedge i_clk) begin
        logic [DW+1:0] t;
        if (o_pop) begin
            for (int k = 0; k < 9; k++) begin
                r_num[k] <= {amag[k], {(2*FRAC_BITS+1){1'b0}}} + NW'(dmag);
                r_rem[k] <= '0;
                r_neg[k] <= i_job.adj[k][AW-1] ^ dneg;
            end
            r_d2   <= {dmag, 1'b0};
            r_sing <= (i_job.det == '0);
        end else if (r_busy) begin
            for (int k = 0; k < 9; k++) begin
                t = {r_rem[k], r_num[k][NW-1]};
                r_num[k] <= {r_num[k][NW-2:0], 1'b0};
                if (t >= {1'b0, r_d2}) begin
                    r_rem[k] <= (DW+1)'(t - {1'b0, r_d2});
                    r_q[k]   <= {r_q[k][QW-2:0], 1'b1};
                end else begin
                    r_rem[k] <= t[DW:0];
                    r_q[k]   <= {r_q[k][QW-2:0], 1'b0};
                end
            end
        end
    end

    // Sequencing.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_cnt <= '0; o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            if (o_pop) begin
                r_busy <= 1'b1; r_cnt <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(QW - 1)) begin
                    r_busy <= 1'b0; o_valid <= 1'b1;
                end
            end
        end
    end

    // Saturation and sign, decoded combinationally from the quotient registers.
    always_comb begin
        logic ovf;
        logic [QW-1:0] lim;
        ovf = 1'b0;
        for (int k = 0; k < 9; k++) begin
            lim = r_neg[k] ? QW'(33'h80000000) : QW'(33'h7FFFFFFF);
            if (r_sing) begin
                o_r[k] = '0;
            end else if (r_q[k] > lim) begin
                o_r[k] = r_neg[k] ? 32'sh80000000 : 32'sh7FFFFFFF;
                ovf = 1'b1;
            end else begin
                o_r[k] = r_neg[k] ? EW'(-r_q[k]) : EW'(r_q[k]);
            end
        end
        o_overflowed = ovf && !r_sing;
        o_singular   = r_sing;
    end

    `ASSERT_IMPLY(a_pop_idle, i_clk, i_rst_n, o_pop, !r_busy, "pop while busy")
    `ASSERT_NEXT(a_busy_after_pop, i_clk, i_rst_n, o_pop, r_busy && !o_valid,
        "no start after pop")
endmodule

// ===== sv/matrix3x3_inverse_core.sv =====
// Throughput is set by the divider bank: each item takes a load and 106 divide steps, and
// the bank takes no new item until the last one is done. From the accepting edge, with the
// back end idle, an item passes 4 front stages, a queue write, a load and 106 steps.
// Items are accepted back to back until the front pipeline and the queue hold 4 items.
// The receiver cannot stall; each result strobe lasts exactly one cycle.
// Reset (synchronous, active low) empties the pipeline and the queue and clears all strobes.
module matrix3x3_inverse_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  mi3_pkg::t_elem       i_a_uu, i_a_uv, i_a_uw,
    input  mi3_pkg::t_elem       i_a_vu, i_a_vv, i_a_vw,
    input  mi3_pkg::t_elem       i_a_wu, i_a_wv, i_a_ww,
    output logic                 o_valid,
    output mi3_pkg::t_elem       o_r_uu, o_r_uv, o_r_uw,
    output mi3_pkg::t_elem       o_r_vu, o_r_vv, o_r_vw,
    output mi3_pkg::t_elem       o_r_wu, o_r_wv, o_r_ww,
    output logic                 o_singular,
    output logic                 o_overflowed
);
    import mi3_pkg::*;

    t_elem  m [9];
    t_elem  r [9];
    logic   f_valid, pop, avail;
    t_job   f_job, q_job;
    t_qstat qs;
    logic [3:0] r_inflight;
    logic [3:0] held;

    assign m = '{i_a_uu, i_a_uv, i_a_uw, i_a_vu, i_a_vv, i_a_vw, i_a_wu, i_a_wv, i_a_ww};

    // Count items in the front pipeline so the queue never overruns.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_inflight <= '0;
        else r_inflight <= {r_inflight[2:0], start && !busy};
    end

    // Items in the front pipeline plus items waiting in the queue.
    assign held = 4'($countones(r_inflight)) + 4'(qs.count);
    assign busy = qs.full || (held >= 4'(QDEPTH));

    mi3_front u_front (.i_clk, .i_rst_n, .i_valid(start && !busy), .i_m(m),
                       .o_valid(f_valid), .o_job(f_job));
    mi3_queue u_queue (.i_clk, .i_rst_n, .i_push(f_valid), .i_job(f_job),
                       .i_pop(pop), .o_job(q_job), .o_stat(qs));
    assign avail = !qs.empty;
    mi3_back u_back (.i_clk, .i_rst_n, .i_avail(avail), .i_job(q_job), .o_pop(pop),
                     .o_valid, .o_r(r), .o_singular, .o_overflowed);

    assign {o_r_uu, o_r_uv, o_r_uw, o_r_vu, o_r_vv, o_r_vw, o_r_wu, o_r_wv, o_r_ww}
        = {r[0], r[1], r[2], r[3], r[4], r[5], r[6], r[7], r[8]};
endmodule
